// ===== rtl/rcnw_pkg.sv =====
// rcnw_pkg: shared types, constants and tables for the ray cast nearest wall unit
// depends on nothing; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package rcnw_pkg;

    localparam int CW        = 16;
    localparam int NSEG      = 8;
    localparam int IDXW      = 3;
    localparam int DISTW     = 17;
    localparam int VW        = 18;
    localparam int PW        = 36;
    localparam int AW        = 38;
    localparam int ZW        = 17;
    localparam int STEPS     = 16;
    localparam logic [DISTW-1:0] DIST_MAX = 17'h1FFFF;
    localparam logic signed [VW-1:0] CORDIC_START = 18'sd9949;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] e1x;
        logic signed [CW-1:0] e1y;
        logic signed [CW-1:0] e2x;
        logic signed [CW-1:0] e2y;
    } seg_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 opcode;
        logic [IDXW-1:0]      seg_index;
        logic signed [CW-1:0] end1_x;
        logic signed [CW-1:0] end1_y;
        logic signed [CW-1:0] end2_x;
        logic signed [CW-1:0] end2_y;
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic [15:0]          heading;
    } cast_in_t;

    typedef struct packed {
        logic             hit;
        logic [DISTW-1:0] distance;
    } cast_out_t;

    function automatic seg_t wall_reset(input logic [IDXW-1:0] k);
        seg_t s;
        unique case (k)
            3'd0: s = '{16'sd0,   16'sd0,   16'sd0,   16'sd768};
            3'd1: s = '{16'sd0,   16'sd768, 16'sd768, 16'sd768};
            3'd2: s = '{16'sd768, 16'sd768, 16'sd768, 16'sd0};
            3'd3: s = '{16'sd768, 16'sd0,   16'sd0,   16'sd0};
            3'd4: s = '{16'sd0,   16'sd256, 16'sd256, 16'sd256};
            3'd5: s = '{16'sd256, 16'sd256, 16'sd256, 16'sd512};
            3'd6: s = '{16'sd512, 16'sd256, 16'sd512, 16'sd512};
            default: s = '{16'sd512, 16'sd384, 16'sd768, 16'sd384};
        endcase
        return s;
    endfunction

    function automatic logic signed [ZW-1:0] angle_step(input logic [3:0] i);
        logic signed [ZW-1:0] a;
        unique case (i)
            4'd0:  a = 17'sd8192;
            4'd1:  a = 17'sd4836;
            4'd2:  a = 17'sd2555;
            4'd3:  a = 17'sd1297;
            4'd4:  a = 17'sd651;
            4'd5:  a = 17'sd326;
            4'd6:  a = 17'sd163;
            4'd7:  a = 17'sd81;
            4'd8:  a = 17'sd41;
            4'd9:  a = 17'sd20;
            4'd10: a = 17'sd10;
            4'd11: a = 17'sd5;
            4'd12: a = 17'sd3;
            4'd13: a = 17'sd1;
            4'd14: a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ray_cast_nearest_wall_unit.sv =====
// ray_cast_nearest_wall_unit: top level, segment ring, shared multipliers and control
// depends on rcnw_pkg, rcnw_seg_cell, rcnw_cordic, rcnw_divider
//
// usage:
//   input channel in_valid/in_ready/in_data carries load and cast transactions.
//   a load writes one slot of the eight-entry wall ring; it gives no result.
//   a cast computes the ray direction with a 16-step rotation unit, then
//   visits the eight segments in turn as the ring rotates past a shared pair
//   of multipliers, stepping through the mul1, mul2, mul3, test and next states
//   for each segment, with a pass through the bit-serial divider for each
//   struck segment that is not saturated.
//   output channel out_valid/out_ready/out_data carries one result per cast
//   (hit flag and nearest distance, q9.8, zero on a miss). the result sits in
//   an output register, so the next transaction is taken while it waits;
//   a finished cast holds until that register is free.
//   in_ready is high whenever no cast is in progress.
//   reset is asynchronous, active low; the ring returns to the eight default
//   walls at once and no output is pending.
`timescale 1ns / 1ps
`default_nettype none

module ray_cast_nearest_wall_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rcnw_pkg::cast_in_t    in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rcnw_pkg::cast_out_t        out_data
);
    import rcnw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_MUL1, S_MUL2, S_MUL3, S_TEST, S_DIV, S_NEXT, S_FIN
    } state_t;

    state_t               state_reg;
    seg_t                 seg_w [NSEG];
    seg_t                 load_val;
    cell_ctrl_t           ctrl_w [NSEG];
    logic signed [CW-1:0] ox_reg, oy_reg;
    logic signed [VW-1:0] v3x_reg, v3y_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pa_next, pb_next;
    logic signed [VW-1:0] ma0, mb0, ma1, mb1;
    logic signed [AW-1:0] den_reg, n1_reg, n2_w, den_a, n1_a, n2_a;
    logic [IDXW-1:0]      cnt_reg;
    logic                 any_reg;
    logic [DISTW-1:0]     best_reg;
    cast_out_t            out_reg;
    logic                 out_valid_reg;
    logic signed [VW-1:0] v1x, v1y, v2x, v2y;
    logic                 struck, sat;
    logic                 take_in, out_free;
    logic                 cor_busy, cor_done, div_busy, div_done, div_start;
    logic signed [VW-1:0] cos_w, sin_w;
    logic [DISTW-1:0]     quot_w;
    logic [AW+2:0]        den_x8;

    assign in_ready = (state_reg == S_IDLE);
    assign take_in  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign load_val = '{in_data.end1_x, in_data.end1_y, in_data.end2_x, in_data.end2_y};

    for (genvar k = 0; k < NSEG; k++)
    begin : g_ring
        assign ctrl_w[k].load  = take_in && (in_data.opcode == OP_LOAD)
                                 && (in_data.seg_index == IDXW'(k));
        assign ctrl_w[k].shift = (state_reg == S_NEXT);
        rcnw_seg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .rst_val  (wall_reset(IDXW'(k))),
            .ctrl     (ctrl_w[k]),
            .load_val (load_val),
            .shift_in (seg_w[(k + 1) % NSEG]),
            .seg      (seg_w[k])
        );
    end

    rcnw_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (take_in && (in_data.opcode == OP_CAST)),
        .heading (in_data.heading),
        .busy    (cor_busy),
        .done    (cor_done),
        .cos_val (cos_w),
        .sin_val (sin_w)
    );

    assign v1x = VW'(ox_reg) - VW'(seg_w[0].e1x);
    assign v1y = VW'(oy_reg) - VW'(seg_w[0].e1y);
    assign v2x = VW'(seg_w[0].e2x) - VW'(seg_w[0].e1x);
    assign v2y = VW'(seg_w[0].e2y) - VW'(seg_w[0].e1y);

    // shared multiplier pair, operands chosen by phase
    always_comb
    begin
        unique case (state_reg)
            S_MUL1:
            begin
                ma0 = v2x; mb0 = v3x_reg; ma1 = v2y; mb1 = v3y_reg;
            end
            S_MUL2:
            begin
                ma0 = v2x; mb0 = v1y; ma1 = v2y; mb1 = v1x;
            end
            default:
            begin
                ma0 = v1x; mb0 = v3x_reg; ma1 = v1y; mb1 = v3y_reg;
            end
        endcase
        pa_next = ma0 * mb0;
        pb_next = ma1 * mb1;
    end

    assign n2_w  = AW'(pa_reg) + AW'(pb_reg);
    assign den_a = den_reg[AW-1] ? -den_reg : den_reg;
    assign n1_a  = den_reg[AW-1] ? -n1_reg  : n1_reg;
    assign n2_a  = den_reg[AW-1] ? -n2_w    : n2_w;
    assign struck = (den_reg != '0) && (n1_a >= 0) && (n2_a >= 0) && (n2_a <= den_a);
    assign den_x8 = {den_a[AW-1:0], 3'b000};
    assign sat    = {3'b000, n1_a[AW-1:0]} >= den_x8;
    assign div_start = (state_reg == S_TEST) && struck && !sat;

    rcnw_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (AW'(n1_a[AW-1:3])),
        .low_bits ({n1_a[2:0], 14'b0}),
        .divisor  (den_a),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (quot_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            any_reg       <= 1'b0;
            best_reg      <= '0;
            out_reg       <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            v3x_reg       <= '0;
            v3y_reg       <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            den_reg       <= '0;
            n1_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take_in && (in_data.opcode == OP_CAST))
                    begin
                        ox_reg    <= in_data.origin_x;
                        oy_reg    <= in_data.origin_y;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (cor_done)
                    begin
                        v3x_reg   <= -sin_w;
                        v3y_reg   <= cos_w;
                        cnt_reg   <= '0;
                        any_reg   <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    pa_reg    <= pa_next;
                    pb_reg    <= pb_next;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    den_reg   <= AW'(pa_reg) + AW'(pb_reg);
                    pa_reg    <= pa_next;
                    pb_reg    <= pb_next;
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    n1_reg    <= AW'(pa_reg) - AW'(pb_reg);
                    pa_reg    <= pa_next;
                    pb_reg    <= pb_next;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (struck && sat)
                    begin
                        if (!any_reg || (DIST_MAX < best_reg))
                        begin
                            best_reg <= DIST_MAX;
                        end
                        any_reg   <= 1'b1;
                        state_reg <= S_NEXT;
                    end
                    else if (struck)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (!any_reg || (quot_w < best_reg))
                        begin
                            best_reg <= quot_w;
                        end
                        any_reg   <= 1'b1;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IDXW'(NSEG - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg.hit      <= any_reg;
                        out_reg.distance <= any_reg ? best_reg : '0;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.hit |-> out_reg.distance == '0)
        else $error("miss result carries a nonzero distance");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && !div_done |-> div_busy)
        else $error("waiting on divider that is not running");

    a_cast_start: assert property (@(posedge clk) disable iff (!rst_n)
        take_in && (in_data.opcode == OP_CAST) |=> cor_busy && (state_reg == S_CORDIC))
        else $error("cast transaction did not start the rotation unit");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> cnt_reg == '0 || $past(state_reg) == S_FIN
        || $past(state_reg) == S_IDLE)
        else $error("segment ring left unaligned");

endmodule

`default_nettype wire

// ===== rtl/rcnw_seg_cell.sv =====
// rcnw_seg_cell: one wall segment cell of the rotating segment ring
// depends on rcnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcnw_seg_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rcnw_pkg::seg_t     rst_val,
    input  wire rcnw_pkg::cell_ctrl_t ctrl,
    input  wire rcnw_pkg::seg_t     load_val,
    input  wire rcnw_pkg::seg_t     shift_in,
    output rcnw_pkg::seg_t          seg
);
    import rcnw_pkg::*;

    seg_t seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= rst_val;
        end
        else if (ctrl.load)
        begin
            seg_reg <= load_val;
        end
        else if (ctrl.shift)
        begin
            seg_reg <= shift_in;
        end
    end

    assign seg = seg_reg;

endmodule

`default_nettype wire

// ===== rtl/rcnw_cordic.sv =====
// rcnw_cordic: iterative rotation giving cos and sin of a binary angle in q1.14
// depends on rcnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcnw_cordic (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [15:0]                 heading,
    output logic                             busy,
    output logic                             done,
    output logic signed [rcnw_pkg::VW-1:0]   cos_val,
    output logic signed [rcnw_pkg::VW-1:0]   sin_val
);
    import rcnw_pkg::*;

    logic signed [VW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next, z0;
    logic [3:0]           i_reg;
    logic                 flip_reg, flip0, busy_reg, done_reg;
    logic signed [ZW-1:0] hz;

    always_comb
    begin
        hz    = ZW'($signed(heading));
        z0    = hz;
        flip0 = 1'b0;
        if (hz > 17'sd16384)
        begin
            z0    = hz - 17'sd32768;
            flip0 = 1'b1;
        end
        else if (hz < -17'sd16384)
        begin
            z0    = hz + 17'sd32768;
            flip0 = 1'b1;
        end
    end

    always_comb
    begin
        if (z_reg >= 0)
        begin
            x_next = x_reg - (y_reg >>> i_reg);
            y_next = y_reg + (x_reg >>> i_reg);
            z_next = z_reg - angle_step(i_reg);
        end
        else
        begin
            x_next = x_reg + (y_reg >>> i_reg);
            y_next = y_reg - (x_reg >>> i_reg);
            z_next = z_reg + angle_step(i_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            flip_reg <= 1'b0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= CORDIC_START;
                y_reg    <= '0;
                z_reg    <= z0;
                flip_reg <= flip0;
            end
            else if (busy_reg)
            begin
                z_reg <= z_next;
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    x_reg    <= flip_reg ? -x_next : x_next;
                    y_reg    <= flip_reg ? -y_next : y_next;
                end
                else
                begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign cos_val = x_reg;
    assign sin_val = y_reg;

endmodule

`default_nettype wire

// ===== rtl/rcnw_divider.sv =====
// rcnw_divider: restoring divider, one quotient bit per cycle, 17-bit quotient
// depends on rcnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcnw_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rcnw_pkg::AW-1:0]       rem_init,
    input  wire logic [rcnw_pkg::DISTW-1:0]    low_bits,
    input  wire logic [rcnw_pkg::AW-1:0]       divisor,
    output logic                               busy,
    output logic                               done,
    output logic [rcnw_pkg::DISTW-1:0]         quot
);
    import rcnw_pkg::*;

    logic [AW-1:0]    rem_reg, den_reg;
    logic [DISTW-1:0] low_reg, q_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [AW:0]      trial;
    logic             ge;

    assign trial = {rem_reg, low_reg[DISTW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            low_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= rem_init;
                den_reg  <= divisor;
                low_reg  <= low_bits;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? AW'(trial - {1'b0, den_reg}) : AW'(trial);
                low_reg <= {low_reg[DISTW-2:0], 1'b0};
                q_reg   <= {q_reg[DISTW-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DISTW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== tb/tb_ray_cast_nearest_wall_unit.sv =====
// tb_ray_cast_nearest_wall_unit: self-checking testbench for the nearest wall ray caster
// holds a wall table and rotation model of its own, drives load and cast transactions
// depends on rcnw_pkg and ray_cast_nearest_wall_unit
`timescale 1ns / 1ps

module tb_ray_cast_nearest_wall_unit;
    import rcnw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_RANDOM     = 430;
    localparam int QUIET_TAIL     = 60;

    class wall_scoreboard;
        longint wall[8][4];
        cast_out_t pending[$];
        int errors;

        function new();
            int k;
            int defaults[8][4] = '{
                '{0, 0, 0, 768}, '{0, 768, 768, 768}, '{768, 768, 768, 0},
                '{768, 0, 0, 0}, '{0, 256, 256, 256}, '{256, 256, 256, 512},
                '{512, 256, 512, 512}, '{512, 384, 768, 384}};
            errors = 0;
            for (k = 0; k < 8; k++)
                for (int j = 0; j < 4; j++)
                    wall[k][j] = defaults[k][j];
        endfunction

        function void heading_vector(input logic [15:0] hd, output longint c, output longint s);
            longint z, x, y, nx;
            bit flip;
            longint steps[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0};
            z = longint'(hd);
            x = 9949;
            y = 0;
            flip = 0;
            if (z >= 32768) z -= 65536;
            if (z > 16384) begin z -= 32768; flip = 1; end
            else if (z < -16384) begin z += 32768; flip = 1; end
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= steps[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += steps[i];
                end
                x = nx;
            end
            if (flip) begin x = -x; y = -y; end
            c = x;
            s = y;
        endfunction

        function void note_input(input cast_in_t it);
            longint ox, oy, c, s, nx3, ny3, v1x, v1y, v2x, v2y, den, n1, n2, d, best;
            bit any;
            cast_out_t r;
            if (it.opcode == OP_LOAD)
            begin
                wall[it.seg_index][0] = longint'(it.end1_x);
                wall[it.seg_index][1] = longint'(it.end1_y);
                wall[it.seg_index][2] = longint'(it.end2_x);
                wall[it.seg_index][3] = longint'(it.end2_y);
                return;
            end
            ox = longint'(it.origin_x);
            oy = longint'(it.origin_y);
            heading_vector(it.heading, c, s);
            nx3 = -s;
            ny3 = c;
            any = 0;
            best = 0;
            for (int k = 0; k < 8; k++)
            begin
                v1x = ox - wall[k][0];
                v1y = oy - wall[k][1];
                v2x = wall[k][2] - wall[k][0];
                v2y = wall[k][3] - wall[k][1];
                den = v2x * nx3 + v2y * ny3;
                n1 = v2x * v1y - v2y * v1x;
                n2 = v1x * nx3 + v1y * ny3;
                if (den == 0) continue;
                if (den < 0) begin den = -den; n1 = -n1; n2 = -n2; end
                if (n1 < 0 || n2 < 0 || n2 > den) continue;
                d = (n1 <<< 14) / den;
                if (d > 131071) d = 131071;
                if (!any || d < best) best = d;
                any = 1;
            end
            r.hit = any;
            r.distance = any ? best[DISTW-1:0] : '0;
            pending.push_back(r);
        endfunction

        function void check_result(input cast_out_t got);
            cast_out_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result hit=%0d distance=%0d", got.hit, got.distance);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit !== exp_r.hit)
            begin
                $error("hit expected %0d actual %0d", exp_r.hit, got.hit);
                errors++;
            end
            if (got.distance !== exp_r.distance)
            begin
                $error("distance expected %0d actual %0d", exp_r.distance, got.distance);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    cast_in_t in_data;
    logic out_valid;
    logic out_ready;
    cast_out_t out_data;

    wall_scoreboard sb;
    bit quiet;
    int stall_left;
    int idle_cycles;

    ray_cast_nearest_wall_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // sink side: check and random backpressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send(input cast_in_t it);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
    endtask

    function automatic cast_in_t load_item(input int idx, input int ax, input int ay,
                                           input int bx, input int by);
        cast_in_t it;
        it = '0;
        it.opcode = OP_LOAD;
        it.seg_index = IDXW'(idx);
        it.end1_x = CW'(ax);
        it.end1_y = CW'(ay);
        it.end2_x = CW'(bx);
        it.end2_y = CW'(by);
        it.origin_x = CW'($urandom);
        it.origin_y = CW'($urandom);
        it.heading = 16'($urandom);
        return it;
    endfunction

    function automatic cast_in_t cast_item(input int ox, input int oy, input int hd);
        cast_in_t it;
        it = '0;
        it.opcode = OP_CAST;
        it.seg_index = IDXW'($urandom);
        it.end1_x = CW'($urandom);
        it.end1_y = CW'($urandom);
        it.end2_x = CW'($urandom);
        it.end2_y = CW'($urandom);
        it.origin_x = CW'(ox);
        it.origin_y = CW'(oy);
        it.heading = 16'(hd);
        return it;
    endfunction

    function automatic int near_coord();
        return $urandom_range(0, 1279) - 256;
    endfunction

    task automatic run_directed();
        int headings[8] = '{0, 16384, 32768, 49152, 65535, 16385, 49151, 8192};
        foreach (headings[k])
            send(cast_item(384, 384, headings[k]));
        send(cast_item(-32768, -32768, 8192));
        send(cast_item(32767, 32767, 40960));
        send(cast_item(32767, -32768, 24576));
        // degenerate wall, then a wall parallel to the ray
        send(load_item(7, 100, 100, 100, 100));
        send(load_item(6, -200, 500, 900, 500));
        send(cast_item(0, 500, 0));
        send(cast_item(100, 0, 16384));
        // extreme endpoints
        send(load_item(5, -32768, -32768, 32767, 32767));
        send(load_item(4, 32767, -32768, -32768, 32767));
        send(cast_item(0, 0, 0));
        send(cast_item(-32768, 32767, 57344));
        send(cast_item(32767, 0, 32768));
        send(load_item(3, -32768, 32767, -32768, -32768));
        send(cast_item(32767, 0, 32768));
    endtask

    task automatic run_random();
        cast_in_t it;
        int sel;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n >= NUM_RANDOM - QUIET_TAIL)
                quiet = 1;
            sel = $urandom_range(0, 99);
            if (sel < 15)
                it = load_item($urandom_range(0, 7), near_coord(), near_coord(),
                               near_coord(), near_coord());
            else if (sel < 20)
            begin
                it = load_item($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 1))
                begin
                    it.end2_x = it.end1_x;
                    it.end2_y = it.end1_y;
                end
            end
            else if (sel < 85)
                it = cast_item(near_coord(), near_coord(), $urandom_range(0, 65535));
            else
                it = cast_item($urandom, $urandom, $urandom);
            send(it);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        stall_left = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rcnw_pkg.sv
rtl/rcnw_seg_cell.sv
rtl/rcnw_cordic.sv
rtl/rcnw_divider.sv
rtl/ray_cast_nearest_wall_unit.sv
tb/tb_ray_cast_nearest_wall_unit.sv
